// ===== rtl/kdd_pkg.sv =====
// kdd_pkg: shared types, constants and lookup functions for the keypad scan /
// digit display core. No dependencies.
package kdd_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam int COLS_W    = 4;
  localparam int ROW_W     = 2;
  localparam int KEY_W     = 4;
  localparam int DIGIT_W   = 4;
  localparam int TICK_W    = 16;
  localparam int ROWS_W    = 4;
  localparam int EN_W      = 6;
  localparam int SEG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [COLS_W-1:0] COLS_IDLE = 4'hF;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CLEAR_A   = 4'd10;
  localparam logic [KEY_W-1:0] KEY_CLEAR_B   = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_HOLD = 1'd1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd5000;
  localparam logic [TICK_W-1:0] HOLD_RST     = 16'd2000;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] code;
  } key_evt_t;

  function automatic logic [SEG_W-1:0] seg_lut(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'h0:    s = 8'h3f;
      4'h1:    s = 8'h06;
      4'h2:    s = 8'h5b;
      4'h3:    s = 8'h4f;
      4'h4:    s = 8'h66;
      4'h5:    s = 8'h6d;
      4'h6:    s = 8'h7d;
      4'h7:    s = 8'h07;
      4'h8:    s = 8'h7f;
      4'h9:    s = 8'h6f;
      4'ha:    s = 8'h77;
      4'hb:    s = 8'h7c;
      4'hc:    s = 8'h39;
      4'hd:    s = 8'h5e;
      4'he:    s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // power-up digits, newest first
  function automatic logic [DIGIT_W-1:0] store_init(input int i);
    logic [DIGIT_W-1:0] d;
    case (i)
      0:       d = 4'd1;
      1:       d = 4'd2;
      2:       d = 4'd3;
      3:       d = 4'd4;
      4:       d = 4'd4;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/kdd_scan.sv =====
// kdd_scan: keypad row scanner with debounce and release wait.
// Depends on kdd_pkg.
module kdd_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [kdd_pkg::COLS_W-1:0]     cols,
  input  logic [kdd_pkg::TICK_W-1:0]     debounce_ticks,
  output logic [kdd_pkg::ROW_W-1:0]      row,
  output kdd_pkg::key_evt_t              key,
  output logic [kdd_pkg::KEY_W-1:0]      last_key
);

  kdd_pkg::phase_t                phase_r, phase_nxt;
  logic [kdd_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [kdd_pkg::TICK_W-1:0]     count_r, count_nxt;
  logic [kdd_pkg::KEY_W-1:0]      last_key_r;
  logic [kdd_pkg::TICK_W-1:0]     cnt_inc;
  logic                           done;
  logic                           idle;
  logic [kdd_pkg::COLS_W-1:0]     low;
  logic                           single;
  logic [1:0]                     col_idx;

  assign cnt_inc = count_r + 16'd1;
  assign done    = (cnt_inc >= debounce_ticks);
  assign idle    = (cols == kdd_pkg::COLS_IDLE);
  assign low     = ~cols;
  assign single  = $onehot(low);

  always_comb begin
    col_idx = 2'd0;
    for (int c = 0; c < kdd_pkg::COLS_W; c++) begin
      if (low[c]) col_idx = 2'(c);
    end
  end

  // next state
  always_comb begin
    case (phase_r)
      kdd_pkg::PH_DEBOUNCE: begin
        if (!done) phase_nxt = kdd_pkg::PH_DEBOUNCE;
        else if (idle) phase_nxt = kdd_pkg::PH_SCAN;
        else phase_nxt = kdd_pkg::PH_RELEASE;
      end
      kdd_pkg::PH_RELEASE: begin
        phase_nxt = idle ? kdd_pkg::PH_SCAN : kdd_pkg::PH_RELEASE;
      end
      default: begin
        phase_nxt = idle ? kdd_pkg::PH_SCAN : kdd_pkg::PH_DEBOUNCE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    key.hit   = 1'b0;
    key.code  = {row_r, col_idx};
    count_nxt = '0;
    case (phase_r)
      kdd_pkg::PH_DEBOUNCE: begin
        count_nxt = done ? '0 : cnt_inc;
        key.hit   = done && !idle && single;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
    row_nxt = (phase_nxt == kdd_pkg::PH_SCAN) ? row_r + 2'd1 : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= kdd_pkg::PH_SCAN;
      row_r      <= '0;
      count_r    <= '0;
      last_key_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      if (key.hit) last_key_r <= key.code;
    end
  end

  assign row      = row_r;
  assign last_key = key.hit ? key.code : last_key_r;

endmodule

// ===== rtl/kdd_display.sv =====
// kdd_display: digit store, refresh counter and seven-segment mux.
// Depends on kdd_pkg.
module kdd_display (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  kdd_pkg::key_evt_t              key,
  input  logic [kdd_pkg::TICK_W-1:0]     hold_ticks,
  output logic [kdd_pkg::EN_W-1:0]       digit_enable,
  output logic [kdd_pkg::SEG_W-1:0]      segments
);

  logic [kdd_pkg::DIGIT_W-1:0]    store_r [kdd_pkg::NUM_DIGITS];
  logic [kdd_pkg::DIG_IDX_W-1:0]  idx_r, idx_nxt;
  logic [kdd_pkg::TICK_W-1:0]     refresh_r, refresh_nxt;
  logic [kdd_pkg::TICK_W-1:0]     refresh_inc;
  logic [kdd_pkg::TICK_W-1:0]     hold;
  logic                           wrap;
  logic                           do_shift;
  logic                           do_clear;

  assign hold        = (hold_ticks == '0) ? 16'd1 : hold_ticks;
  assign refresh_inc = refresh_r + 16'd1;
  assign wrap        = (refresh_inc >= hold);
  assign refresh_nxt = wrap ? '0 : refresh_inc;
  assign idx_nxt     = !wrap ? idx_r :
                       (idx_r == kdd_pkg::DIG_IDX_W'(kdd_pkg::NUM_DIGITS - 1)) ? '0 :
                       idx_r + kdd_pkg::DIG_IDX_W'(1);

  assign do_shift = key.hit && (key.code <= kdd_pkg::KEY_DIGIT_MAX);
  assign do_clear = key.hit && (key.code inside {kdd_pkg::KEY_CLEAR_A, kdd_pkg::KEY_CLEAR_B});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      refresh_r <= '0;
      for (int i = 0; i < kdd_pkg::NUM_DIGITS; i++) begin
        store_r[i] <= kdd_pkg::store_init(i);
      end
    end else if (step) begin
      idx_r     <= idx_nxt;
      refresh_r <= refresh_nxt;
      if (do_clear) begin
        for (int i = 0; i < kdd_pkg::NUM_DIGITS; i++) begin
          store_r[i] <= '0;
        end
      end else if (do_shift) begin
        for (int i = kdd_pkg::NUM_DIGITS - 1; i > 0; i--) begin
          store_r[i] <= store_r[i-1];
        end
        store_r[0] <= key.code;
      end
    end
  end

  // digit i lights enable bit NUM_DIGITS-1-i; bits past the field drop out
  always_comb begin
    for (int b = 0; b < kdd_pkg::EN_W; b++) begin
      digit_enable[b] = !(int'(idx_r) == kdd_pkg::NUM_DIGITS - 1 - b);
    end
  end

  assign segments = kdd_pkg::seg_lut(store_r[idx_r]);

endmodule

// ===== rtl/keypad_scan_digit_display_core.sv =====
// keypad_scan_digit_display_core: top level, config registers and result register.
// Depends on kdd_pkg, kdd_scan, kdd_display.
//
//   channel  ports                                   direction
//   in       in_valid/in_stall, in_column_lines      item in, one sample tick
//   out      out_valid/out_stall, out_row_drive,     item out, one per input item
//            out_digit_enable, out_segments,
//            out_key_event, out_key_code
//   cfg      cfg_wr_en, cfg_index, cfg_data          register write
//
// One item per clock while in_stall is low; its result is registered in the output register.
// The result register frees in the cycle it is taken, so throughput is one item
// per clock while out_stall is low; in_stall follows a held, stalled result.
// Reset is synchronous (rst_n low): scanner idle on row 0, digits 1,2,3,4,4,0.
module keypad_scan_digit_display_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [kdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kdd_pkg::TICK_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kdd_pkg::COLS_W-1:0]        in_column_lines,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kdd_pkg::ROWS_W-1:0]        out_row_drive,
  output logic [kdd_pkg::EN_W-1:0]          out_digit_enable,
  output logic [kdd_pkg::SEG_W-1:0]         out_segments,
  output logic                              out_key_event,
  output logic [kdd_pkg::KEY_W-1:0]         out_key_code
);

  logic [kdd_pkg::TICK_W-1:0]  debounce_r;
  logic [kdd_pkg::TICK_W-1:0]  hold_r;
  logic                        step;
  logic                        out_valid_r, out_valid_nxt;
  logic [kdd_pkg::ROW_W-1:0]   row;
  kdd_pkg::key_evt_t           key;
  logic [kdd_pkg::KEY_W-1:0]   last_key;
  logic [kdd_pkg::EN_W-1:0]    digit_enable;
  logic [kdd_pkg::SEG_W-1:0]   segments;
  logic [kdd_pkg::ROWS_W-1:0]  row_drive;

  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= kdd_pkg::DEBOUNCE_RST;
      hold_r     <= kdd_pkg::HOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        kdd_pkg::CFG_DEBOUNCE:   debounce_r <= cfg_data;
        kdd_pkg::CFG_DIGIT_HOLD: hold_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  kdd_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .cols           (in_column_lines),
    .debounce_ticks (debounce_r),
    .row            (row),
    .key            (key),
    .last_key       (last_key)
  );

  kdd_display u_display (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .key          (key),
    .hold_ticks   (hold_r),
    .digit_enable (digit_enable),
    .segments     (segments)
  );

  assign row_drive     = ~(kdd_pkg::ROWS_W'(1) << row);
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_row_drive    <= row_drive;
      out_digit_enable <= digit_enable;
      out_segments     <= segments;
      out_key_event    <= key.hit;
      out_key_code     <= last_key;
    end
  end

  assign out_valid = out_valid_r;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("accepted item produced no result");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_one_row_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(~out_row_drive) == 1) && ($countones(~out_digit_enable) <= 1))
    else $error("more than one row or digit selected");

  a_event_code_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) && !$past(key.hit) && $past(out_valid) |-> $stable(out_key_code))
    else $error("key code changed without a key");

endmodule
